// ----- src/clts_pkg.sv -----
// package: word types, token codes and byte classification for the token scanner
`default_nettype none
package clts_pkg;

    localparam int NUM_W = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_text;
    } source_word_t;

    typedef struct packed {
        logic [3:0]       token_kind;
        logic [4:0]       token_code;
        logic [NUM_W-1:0] number_value;
        logic [7:0]       char_value;
        logic             overflowed;
        logic             last_of_run;
    } token_word_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_STR,
        MODE_CHV,
        MODE_CHC,
        MODE_OP
    } scan_mode_t;

    localparam logic [3:0] KIND_IDENT_CHAR  = 4'd0;
    localparam logic [3:0] KIND_IDENT_END   = 4'd1;
    localparam logic [3:0] KIND_NUMBER      = 4'd2;
    localparam logic [3:0] KIND_STRING_CHAR = 4'd3;
    localparam logic [3:0] KIND_STRING_END  = 4'd4;
    localparam logic [3:0] KIND_CHAR_LIT    = 4'd5;
    localparam logic [3:0] KIND_OPERATOR    = 4'd6;
    localparam logic [3:0] KIND_PUNCT       = 4'd7;
    localparam logic [3:0] KIND_ERROR       = 4'd8;

    localparam logic [4:0] CODE_NONE      = 5'd0;
    localparam logic [4:0] ERR_BAD_PAIR   = 5'd0;
    localparam logic [4:0] ERR_OPEN_CHAR  = 5'd1;
    localparam logic [4:0] CODE_OR_OR     = 5'd13;
    localparam logic [4:0] CODE_AND_AND   = 5'd14;

    // single operator indexes
    localparam logic [3:0] OP_PLUS  = 4'd0;
    localparam logic [3:0] OP_MINUS = 4'd1;
    localparam logic [3:0] OP_STAR  = 4'd2;
    localparam logic [3:0] OP_SLASH = 4'd3;
    localparam logic [3:0] OP_PCT   = 4'd4;
    localparam logic [3:0] OP_BAR   = 4'd5;
    localparam logic [3:0] OP_AMP   = 4'd6;
    localparam logic [3:0] OP_CARET = 4'd7;
    localparam logic [3:0] OP_TILDE = 4'd8;
    localparam logic [3:0] OP_BANG  = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_GT    = 4'd11;
    localparam logic [3:0] OP_LT    = 4'd12;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } lookup_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[CH_ZERO:CH_NINE]});
    endfunction

    function automatic lookup_t op_lookup(input logic [7:0] b);
        lookup_t r;
        r.hit = 1'b1;
        r.idx = OP_PLUS;
        case (b)
            8'h2B:   r.idx = OP_PLUS;
            8'h2D:   r.idx = OP_MINUS;
            8'h2A:   r.idx = OP_STAR;
            8'h2F:   r.idx = OP_SLASH;
            8'h25:   r.idx = OP_PCT;
            8'h7C:   r.idx = OP_BAR;
            8'h26:   r.idx = OP_AMP;
            8'h5E:   r.idx = OP_CARET;
            8'h7E:   r.idx = OP_TILDE;
            8'h21:   r.idx = OP_BANG;
            8'h3D:   r.idx = OP_EQ;
            8'h3E:   r.idx = OP_GT;
            8'h3C:   r.idx = OP_LT;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic lookup_t punct_lookup(input logic [7:0] b);
        lookup_t r;
        r.hit = 1'b1;
        r.idx = 4'd0;
        case (b)
            8'h28:   r.idx = 4'd0;
            8'h29:   r.idx = 4'd1;
            8'h7B:   r.idx = 4'd2;
            8'h7D:   r.idx = 4'd3;
            8'h5B:   r.idx = 4'd4;
            8'h5D:   r.idx = 4'd5;
            8'h3B:   r.idx = 4'd6;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // code of "x=" for a held operator; zero means no such pair
    function automatic logic [4:0] eq_pair_code(input logic [3:0] idx);
        logic [4:0] c;
        case (idx)
            OP_PLUS:  c = 5'd19;
            OP_MINUS: c = 5'd20;
            OP_STAR:  c = 5'd21;
            OP_SLASH: c = 5'd22;
            OP_PCT:   c = 5'd23;
            OP_BAR:   c = 5'd24;
            OP_AMP:   c = 5'd25;
            OP_CARET: c = 5'd26;
            OP_BANG:  c = 5'd16;
            OP_EQ:    c = 5'd15;
            OP_GT:    c = 5'd18;
            OP_LT:    c = 5'd17;
            default:  c = 5'd0;
        endcase
        return c;
    endfunction

    function automatic logic can_double(input logic [3:0] idx);
        return (idx inside {OP_PLUS, OP_MINUS, OP_BAR, OP_AMP, OP_LT, OP_GT});
    endfunction

    function automatic token_word_t make_token(
        input logic [3:0]       kind,
        input logic [4:0]       code,
        input logic [NUM_W-1:0] num,
        input logic [7:0]       ch,
        input logic             ovf
    );
        token_word_t t;
        t.token_kind   = kind;
        t.token_code   = code;
        t.number_value = num;
        t.char_value   = ch;
        t.overflowed   = ovf;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- src/c_like_token_scanner.sv -----
// top level: byte-serial scanner for c-like source text with a three-entry token queue
`default_nettype none
// Takes one source byte per word and emits zero, one or two token words per byte.
// A byte is decoded in the cycle it is accepted and its tokens show at the output
// from the next cycle on, through a three-entry queue; the input is ready while
// the queue holds at most one token. With a downstream that always takes tokens,
// one byte is accepted every cycle as long as bytes give at most one token; a byte
// that gives two (a token closed by a letter or punctuation byte that gives a token
// of its own) holds the input back, as the output side moves one token per cycle.
module c_like_token_scanner (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        source_valid,
    output logic                             source_ready,
    input  wire clts_pkg::source_word_t      source_word,
    output logic                             token_valid,
    input  wire logic                        token_ready,
    output clts_pkg::token_word_t            token_word
);
    import clts_pkg::*;

    scan_mode_t       mode_reg, mode_next;
    logic [3:0]       held_reg, held_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;

    token_word_t      q_reg [3];
    token_word_t      q_next [3];
    logic [1:0]       count_reg, count_next;

    logic             accept, pop;
    logic [7:0]       b;
    lookup_t          b_op, b_punct;
    logic             b_alpha, b_digit;
    logic [34:0]      acc_wide;

    // decode of the byte as the start of a new token
    scan_mode_t       fresh_mode;
    logic             fresh_emit;
    token_word_t      fresh_tok;

    logic             pre_emit, use_fresh;
    token_word_t      pre_tok;
    logic [1:0]       n_tok;
    token_word_t      tok0, tok1;
    logic [1:0]       base;

    assign source_ready = ~count_reg[1];
    assign accept       = source_valid & source_ready;
    assign token_valid  = (count_reg != 2'd0);
    assign token_word   = q_reg[0];
    assign pop          = token_valid & token_ready;

    assign b       = source_word.source_byte;
    assign b_op    = op_lookup(b);
    assign b_punct = punct_lookup(b);
    assign b_alpha = is_alpha(b);
    assign b_digit = is_digit(b);
    assign acc_wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {31'd0, b[3:0]};

    always_comb
    begin
        fresh_mode = MODE_IDLE;
        fresh_emit = 1'b0;
        fresh_tok  = make_token(KIND_IDENT_CHAR, CODE_NONE, '0, 8'd0, 1'b0);
        if (b_alpha)
        begin
            fresh_mode = MODE_IDENT;
            fresh_emit = 1'b1;
            fresh_tok  = make_token(KIND_IDENT_CHAR, CODE_NONE, '0, b, 1'b0);
        end
        else if (b_digit)
        begin
            fresh_mode = MODE_NUM;
        end
        else if (b == CH_QUOTE)
        begin
            fresh_mode = MODE_STR;
        end
        else if (b == CH_APOS)
        begin
            fresh_mode = MODE_CHV;
        end
        else if (b_op.hit)
        begin
            fresh_mode = MODE_OP;
        end
        else if (b_punct.hit)
        begin
            fresh_emit = 1'b1;
            fresh_tok  = make_token(KIND_PUNCT, {1'b0, b_punct.idx}, '0, 8'd0, 1'b0);
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        pre_emit  = 1'b0;
        pre_tok   = make_token(KIND_IDENT_CHAR, CODE_NONE, '0, 8'd0, 1'b0);
        use_fresh = 1'b0;

        if (source_word.end_of_text)
        begin
            mode_next = MODE_IDLE;
            held_next = OP_PLUS;
            acc_next  = '0;
            sat_next  = 1'b0;
            case (mode_reg)
                MODE_IDENT:
                begin
                    pre_emit = 1'b1;
                    pre_tok  = make_token(KIND_IDENT_END, CODE_NONE, '0, 8'd0, 1'b0);
                end
                MODE_NUM:
                begin
                    pre_emit = 1'b1;
                    pre_tok  = make_token(KIND_NUMBER, CODE_NONE, acc_reg, 8'd0, sat_reg);
                end
                MODE_STR:
                begin
                    pre_emit = 1'b1;
                    pre_tok  = make_token(KIND_STRING_END, CODE_NONE, '0, 8'd0, 1'b0);
                end
                MODE_CHV:
                begin
                    pre_emit = 1'b1;
                    pre_tok  = make_token(KIND_ERROR, ERR_OPEN_CHAR, '0, 8'd0, 1'b0);
                end
                MODE_OP:
                begin
                    pre_emit = 1'b1;
                    pre_tok  = make_token(KIND_OPERATOR, {1'b0, held_reg}, '0, 8'd0, 1'b0);
                end
                default:
                begin
                    pre_emit = 1'b0;
                end
            endcase
        end
        else
        begin
            case (mode_reg)
                MODE_IDENT:
                begin
                    if (b_alpha || b_digit)
                    begin
                        pre_emit = 1'b1;
                        pre_tok  = make_token(KIND_IDENT_CHAR, CODE_NONE, '0, b, 1'b0);
                    end
                    else
                    begin
                        pre_emit  = 1'b1;
                        pre_tok   = make_token(KIND_IDENT_END, CODE_NONE, '0, 8'd0, 1'b0);
                        use_fresh = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (b_digit)
                    begin
                        if (acc_wide > {4'd0, NUM_MAX})
                        begin
                            acc_next = NUM_MAX;
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = acc_wide[NUM_W-1:0];
                        end
                    end
                    else
                    begin
                        pre_emit  = 1'b1;
                        pre_tok   = make_token(KIND_NUMBER, CODE_NONE, acc_reg, 8'd0, sat_reg);
                        acc_next  = '0;
                        sat_next  = 1'b0;
                        use_fresh = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    pre_emit = 1'b1;
                    if (b == CH_QUOTE)
                    begin
                        pre_tok   = make_token(KIND_STRING_END, CODE_NONE, '0, 8'd0, 1'b0);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        pre_tok = make_token(KIND_STRING_CHAR, CODE_NONE, '0, b, 1'b0);
                    end
                end
                MODE_CHV:
                begin
                    pre_emit  = 1'b1;
                    pre_tok   = make_token(KIND_CHAR_LIT, CODE_NONE, '0, b, 1'b0);
                    mode_next = MODE_CHC;
                end
                MODE_CHC:
                begin
                    mode_next = MODE_IDLE;
                end
                MODE_OP:
                begin
                    pre_emit = 1'b1;
                    if (b == CH_EQUALS)
                    begin
                        mode_next = MODE_IDLE;
                        if (eq_pair_code(held_reg) == CODE_NONE)
                        begin
                            pre_tok = make_token(KIND_ERROR, ERR_BAD_PAIR, '0, 8'd0, 1'b0);
                        end
                        else
                        begin
                            pre_tok = make_token(KIND_OPERATOR, eq_pair_code(held_reg),
                                                 '0, 8'd0, 1'b0);
                        end
                    end
                    else if (b_op.hit && (b_op.idx == held_reg) && can_double(held_reg))
                    begin
                        mode_next = MODE_IDLE;
                        if (held_reg == OP_BAR)
                        begin
                            pre_tok = make_token(KIND_OPERATOR, CODE_OR_OR, '0, 8'd0, 1'b0);
                        end
                        else if (held_reg == OP_AMP)
                        begin
                            pre_tok = make_token(KIND_OPERATOR, CODE_AND_AND, '0, 8'd0, 1'b0);
                        end
                        else
                        begin
                            pre_tok = make_token(KIND_ERROR, ERR_BAD_PAIR, '0, 8'd0, 1'b0);
                        end
                    end
                    else
                    begin
                        pre_tok   = make_token(KIND_OPERATOR, {1'b0, held_reg}, '0, 8'd0, 1'b0);
                        use_fresh = 1'b1;
                    end
                end
                default:
                begin
                    use_fresh = 1'b1;
                end
            endcase

            if (use_fresh)
            begin
                mode_next = fresh_mode;
                if (b_digit)
                begin
                    acc_next = {{(NUM_W-4){1'b0}}, b[3:0]};
                    sat_next = 1'b0;
                end
                if (b_op.hit)
                begin
                    held_next = b_op.idx;
                end
            end
        end
    end

    // pack up to two tokens, marking the last one of this byte
    always_comb
    begin
        tok0  = pre_emit ? pre_tok : fresh_tok;
        tok1  = fresh_tok;
        n_tok = 2'd0;
        if (pre_emit && use_fresh && fresh_emit)
        begin
            n_tok = 2'd2;
            tok1.last_of_run = 1'b1;
        end
        else if (pre_emit || (use_fresh && fresh_emit))
        begin
            n_tok = 2'd1;
            tok0.last_of_run = 1'b1;
        end
    end

    // token queue, head at entry zero
    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < 3; i++)
        begin
            if (pop && (i < 2))
            begin
                q_next[i] = q_reg[i+1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (accept && (n_tok != 2'd0) && (2'(i) == base))
            begin
                q_next[i] = tok0;
            end
            if (accept && (n_tok == 2'd2) && (2'(i) == base + 2'd1))
            begin
                q_next[i] = tok1;
            end
        end
        count_next = base + (accept ? n_tok : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            held_reg  <= OP_PLUS;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                acc_reg  <= acc_next;
                sat_reg  <= sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

`ifndef SYNTHESIS
    a_acc_only_in_number: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_NUM) |-> ((acc_reg == '0) && !sat_reg))
        else $error("accumulator not clear outside a number");

    a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (acc_reg == NUM_MAX))
        else $error("saturated number not at maximum");

    a_held_is_operator: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OP) |-> (held_reg <= OP_LT))
        else $error("held operator index out of range");

    a_end_clears_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && source_word.end_of_text) |=> (mode_reg == MODE_IDLE))
        else $error("end of text left scanner busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd3) |-> !source_ready)
        else $error("queue full but input ready");
`endif

endmodule
`default_nettype wire
